// ===== rtl/mpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Masked Potts energy: shared package
// Sizes, payload types and accumulator limits used across the energy pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package mpe_pkg;

  // Lattice limits.
  localparam int MAX_LABELS = 8;
  localparam int MAX_COLS   = 1024;

  // Field widths fixed by the interface.
  localparam int CELL_W = 4;   // label field
  localparam int TIDX_W = 3;   // table row and column fields
  localparam int LEN_W  = 11;  // row length register
  localparam int VAL_W  = 16;  // Q7.8 table value
  localparam int ACC_W  = 32;  // Q23.8 energy

  // Derived widths.
  localparam int LIDX_W     = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int CNT_W      = $clog2(MAX_COLS + 1);
  localparam int PAIR_AW    = 2 * LIDX_W;
  localparam int PAIR_DEPTH = 1 << PAIR_AW;
  localparam int PSUM_W     = VAL_W + 2;  // sum of three table values

  // Accumulator limits.
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Item kinds on the input channel; the fourth code is ignored.
  typedef enum logic [1:0] {
    MODE_PAIR  = 2'd0,
    MODE_FIELD = 2'd1,
    MODE_PIXEL = 2'd2
  } mode_t;

  typedef logic [CELL_W-1:0] cell_t;

  // A pixel after position tracking, waiting for its upper neighbour.
  typedef struct packed {
    cell_t cur;
    cell_t left;
    logic  has_left;
    logic  has_up;
    logic  fend;
  } pix_t;

  // Energy terms of one pixel, prepared for the accumulator.
  // p1..p3 are running sums of the left, upper and field terms; hi and lo
  // are the values the accumulator ends on when it clips at the given step.
  typedef struct packed {
    logic signed [PSUM_W-1:0] p1;
    logic signed [PSUM_W-1:0] p2;
    logic signed [PSUM_W-1:0] p3;
    logic signed [ACC_W-1:0]  hi1;
    logic signed [ACC_W-1:0]  lo1;
    logic signed [ACC_W-1:0]  hi2;
    logic signed [ACC_W-1:0]  lo2;
    logic                     fend;
  } terms_t;

endpackage

`default_nettype wire

// ===== rtl/masked_potts_energy_field.sv =====
// ----------------------------------------------------------------------------
// Masked Potts energy with per-label field
// Top level: position tracking, table lookup and saturating accumulation.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock cycle while in_ready is high, table
// writes and pixels alike; the last pixel of a frame passes the pixel, lookup
// and term registers and its frame energy is reported from the result register.
// The rate is set by the line store, which serves one read and one write per
// pixel, and by the accumulator, which adds all three terms of a pixel at once.
// After reset the line store is cleared one column per cycle, and in_ready
// stays low until every column is cleared; configuration beats are taken
// during that time. While a frame result sits unclaimed in the output register,
// the pipeline stops only when the next frame result reaches the accumulator.
`default_nettype none

module masked_potts_energy_field (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mpe_pkg::LEN_W-1:0]         cfg_row_length,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_mode,
  input  wire logic [mpe_pkg::CELL_W-1:0]        in_label,
  input  wire logic                              in_mask_in,
  input  wire logic                              in_frame_end,
  input  wire logic [mpe_pkg::TIDX_W-1:0]        in_table_row,
  input  wire logic [mpe_pkg::TIDX_W-1:0]        in_table_col,
  input  wire logic signed [mpe_pkg::VAL_W-1:0]  in_table_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [mpe_pkg::ACC_W-1:0]       out_energy,
  output logic                                   out_saturated
);

  logic            adv;
  logic            in_beat;
  logic            pair_we;
  logic            field_we;
  logic            s1_valid;
  mpe_pkg::pix_t   s1_pix;
  mpe_pkg::cell_t  up_cell;
  logic            s3_valid;
  mpe_pkg::terms_t s3_terms;

  // Table writes land as soon as their beat is taken.
  assign in_beat  = in_valid && in_ready;
  assign pair_we  = in_beat && (in_mode == mpe_pkg::MODE_PAIR);
  assign field_we = in_beat && (in_mode == mpe_pkg::MODE_FIELD);

  mpe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_row_length (cfg_row_length),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_label       (in_label),
    .in_mask_in     (in_mask_in),
    .in_frame_end   (in_frame_end),
    .s1_valid_r     (s1_valid),
    .s1_pix_r       (s1_pix),
    .up_cell        (up_cell)
  );

  mpe_lookup u_lookup (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .pair_we    (pair_we),
    .field_we   (field_we),
    .tbl_row    (in_table_row),
    .tbl_col    (in_table_col),
    .tbl_value  (in_table_value),
    .s1_valid   (s1_valid),
    .s1_pix     (s1_pix),
    .up_cell    (up_cell),
    .s3_valid_r (s3_valid),
    .s3_terms_r (s3_terms)
  );

  mpe_accum u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .s3_valid      (s3_valid),
    .s3_terms      (s3_terms),
    .adv           (adv),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_energy    (out_energy),
    .out_saturated (out_saturated)
  );

endmodule

`default_nettype wire

// ===== rtl/mpe_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered, read-first data.
// ----------------------------------------------------------------------------
`default_nettype none

module mpe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/mpe_front.sv =====
// ----------------------------------------------------------------------------
// Masked Potts energy: position tracker and line store
// Holds the row length, tracks the raster position, keeps the previous row
// of cells and clears the line store after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mpe_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       adv,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [mpe_pkg::LEN_W-1:0]  cfg_row_length,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_mode,
  input  wire logic [mpe_pkg::CELL_W-1:0] in_label,
  input  wire logic                       in_mask_in,
  input  wire logic                       in_frame_end,
  output logic                            s1_valid_r,
  output mpe_pkg::pix_t                   s1_pix_r,
  output mpe_pkg::cell_t                  up_cell
);

  localparam int COL_W  = mpe_pkg::COL_W;
  localparam int CNT_W  = mpe_pkg::CNT_W;
  localparam int CELL_W = mpe_pkg::CELL_W;
  localparam int LEN_W  = mpe_pkg::LEN_W;

  logic [LEN_W-1:0]  row_length_r;
  logic              clr_busy_r;
  logic [COL_W-1:0]  clr_addr_r;
  logic [COL_W-1:0]  col_r;
  logic [COL_W-1:0]  col_nxt;
  mpe_pkg::cell_t    left_r;
  mpe_pkg::cell_t    left_nxt;
  logic              first_row_r;
  logic              first_row_nxt;
  logic              pix_acc;
  logic              label_ok;
  mpe_pkg::cell_t    cur;
  logic [CNT_W-1:0]  len_eff;
  logic [CNT_W-1:0]  col_inc;
  logic              ls_we;
  logic [COL_W-1:0]  ls_waddr;
  mpe_pkg::cell_t    ls_wdata;

  // Configuration beats are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= LEN_W'(mpe_pkg::MAX_COLS);
    end else if (cfg_valid) begin
      row_length_r <= cfg_row_length;
    end
  end

  // Clearing pass over the line store, one entry per cycle after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + COL_W'(1);
      if (clr_addr_r == COL_W'(mpe_pkg::MAX_COLS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign in_ready = adv && !clr_busy_r;
  assign pix_acc  = in_valid && in_ready && (in_mode == mpe_pkg::MODE_PIXEL);

  // Effective label: zero unless the cell is masked in and in range.
  assign label_ok = (in_label != '0) && (32'(in_label) <= 32'(mpe_pkg::MAX_LABELS));
  assign cur      = (in_mask_in && label_ok) ? in_label : '0;

  // Row length clamped to one through the line store depth.
  always_comb begin
    priority if (row_length_r == '0) begin
      len_eff = CNT_W'(1);
    end else if (32'(row_length_r) > 32'(mpe_pkg::MAX_COLS)) begin
      len_eff = CNT_W'(mpe_pkg::MAX_COLS);
    end else begin
      len_eff = CNT_W'(row_length_r);
    end
  end

  assign col_inc = CNT_W'(col_r) + CNT_W'(1);

  // Raster position update for an accepted pixel.
  always_comb begin
    col_nxt       = col_r;
    left_nxt      = left_r;
    first_row_nxt = first_row_r;
    if (pix_acc) begin
      left_nxt = cur;
      if (col_inc >= len_eff) begin
        col_nxt       = '0;
        first_row_nxt = 1'b0;
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
      if (in_frame_end) begin
        col_nxt       = '0;
        left_nxt      = '0;
        first_row_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      left_r      <= '0;
      first_row_r <= 1'b1;
    end else begin
      col_r       <= col_nxt;
      left_r      <= left_nxt;
      first_row_r <= first_row_nxt;
    end
  end

  // Line store: the pixel reads its column and writes its own cell back.
  assign ls_we    = clr_busy_r || pix_acc;
  assign ls_waddr = clr_busy_r ? clr_addr_r : col_r;
  assign ls_wdata = clr_busy_r ? '0 : cur;

  mpe_ram #(
    .WIDTH (CELL_W),
    .DEPTH (mpe_pkg::MAX_COLS)
  ) u_line_store (
    .clk   (clk),
    .we    (ls_we),
    .waddr (ls_waddr),
    .wdata (ls_wdata),
    .re    (pix_acc),
    .raddr (col_r),
    .rdata (up_cell)
  );

  // Pixel register feeding the table lookup.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= pix_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_pix_r.cur      <= cur;
      s1_pix_r.left     <= left_r;
      s1_pix_r.has_left <= (col_r != '0);
      s1_pix_r.has_up   <= !first_row_r;
      s1_pix_r.fend     <= in_frame_end;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mpe_lookup.sv =====
// ----------------------------------------------------------------------------
// Masked Potts energy: table lookup and term preparation
// Holds the pair and field tables, looks up the three energy terms of a
// pixel and prepares the running sums and clip values for the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module mpe_lookup (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             adv,
  input  wire logic                             pair_we,
  input  wire logic                             field_we,
  input  wire logic [mpe_pkg::TIDX_W-1:0]       tbl_row,
  input  wire logic [mpe_pkg::TIDX_W-1:0]       tbl_col,
  input  wire logic signed [mpe_pkg::VAL_W-1:0] tbl_value,
  input  wire logic                             s1_valid,
  input  wire mpe_pkg::pix_t                    s1_pix,
  input  wire mpe_pkg::cell_t                   up_cell,
  output logic                                  s3_valid_r,
  output mpe_pkg::terms_t                       s3_terms_r
);

  localparam int LIDX_W  = mpe_pkg::LIDX_W;
  localparam int CELL_W  = mpe_pkg::CELL_W;
  localparam int VAL_W   = mpe_pkg::VAL_W;
  localparam int ACC_W   = mpe_pkg::ACC_W;
  localparam int PSUM_W  = mpe_pkg::PSUM_W;
  localparam int PAIR_AW = mpe_pkg::PAIR_AW;

  // The table is symmetric, so each pair lives at its sorted address.
  function automatic logic [PAIR_AW-1:0] pair_addr(input logic [LIDX_W-1:0] a,
                                                   input logic [LIDX_W-1:0] b);
    return (a < b) ? {a, b} : {b, a};
  endfunction

  function automatic logic signed [PSUM_W-1:0] sext_val(input logic signed [VAL_W-1:0] v);
    return {{(PSUM_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

  function automatic logic signed [ACC_W-1:0] sext_acc(input logic signed [PSUM_W-1:0] v);
    return {{(ACC_W-PSUM_W){v[PSUM_W-1]}}, v};
  endfunction

  logic                      row_ok;
  logic                      col_ok;
  logic [PAIR_AW-1:0]        wr_addr;
  logic                      pair_wr;
  logic signed [VAL_W-1:0]   field_mem_r [mpe_pkg::MAX_LABELS];
  mpe_pkg::cell_t            up;
  logic [LIDX_W-1:0]         cur_idx;
  logic [LIDX_W-1:0]         left_idx;
  logic [LIDX_W-1:0]         up_idx;
  logic                      left_hit;
  logic                      up_hit;
  logic [PAIR_AW-1:0]        left_addr;
  logic [PAIR_AW-1:0]        up_addr;
  logic [VAL_W-1:0]          left_data;
  logic [VAL_W-1:0]          up_data;
  logic                      s2_valid_r;
  logic                      s2_left_hit_r;
  logic                      s2_up_hit_r;
  logic                      s2_own_r;
  logic signed [VAL_W-1:0]   s2_field_r;
  logic                      s2_fend_r;
  logic signed [PSUM_W-1:0]  tx;
  logic signed [PSUM_W-1:0]  ty;
  logic signed [PSUM_W-1:0]  tz;
  logic signed [PSUM_W-1:0]  hi_y;
  logic signed [PSUM_W-1:0]  lo_y;
  logic signed [PSUM_W-1:0]  hi_yz;
  logic signed [PSUM_W-1:0]  lo_yz;
  logic signed [PSUM_W-1:0]  hi_z;
  logic signed [PSUM_W-1:0]  lo_z;
  mpe_pkg::terms_t           terms;

  // Table writes; an index beyond the label count is dropped.
  assign row_ok  = 32'(tbl_row) < 32'(mpe_pkg::MAX_LABELS);
  assign col_ok  = 32'(tbl_col) < 32'(mpe_pkg::MAX_LABELS);
  assign pair_wr = pair_we && row_ok && col_ok;
  assign wr_addr = pair_addr(LIDX_W'(tbl_row), LIDX_W'(tbl_col));

  always_ff @(posedge clk) begin
    if (field_we && row_ok) begin
      field_mem_r[LIDX_W'(tbl_row)] <= tbl_value;
    end
  end

  // Neighbour pairs count only between two different nonzero cells.
  assign up       = s1_pix.has_up ? up_cell : '0;
  assign cur_idx  = LIDX_W'(s1_pix.cur - CELL_W'(1));
  assign left_idx = LIDX_W'(s1_pix.left - CELL_W'(1));
  assign up_idx   = LIDX_W'(up - CELL_W'(1));
  assign left_hit = s1_pix.has_left && (s1_pix.cur != '0) && (s1_pix.left != '0) &&
                    (s1_pix.cur != s1_pix.left);
  assign up_hit   = (s1_pix.cur != '0) && (up != '0) && (s1_pix.cur != up);
  assign left_addr = pair_addr(cur_idx, left_idx);
  assign up_addr   = pair_addr(cur_idx, up_idx);

  // Two copies of the pair table give one lookup per neighbour.
  mpe_ram #(
    .WIDTH (VAL_W),
    .DEPTH (mpe_pkg::PAIR_DEPTH)
  ) u_pair_left (
    .clk   (clk),
    .we    (pair_wr),
    .waddr (wr_addr),
    .wdata (tbl_value),
    .re    (adv),
    .raddr (left_addr),
    .rdata (left_data)
  );

  mpe_ram #(
    .WIDTH (VAL_W),
    .DEPTH (mpe_pkg::PAIR_DEPTH)
  ) u_pair_up (
    .clk   (clk),
    .we    (pair_wr),
    .waddr (wr_addr),
    .wdata (tbl_value),
    .re    (adv),
    .raddr (up_addr),
    .rdata (up_data)
  );

  // Lookup stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_left_hit_r <= left_hit;
      s2_up_hit_r   <= up_hit;
      s2_own_r      <= (s1_pix.cur != '0);
      s2_field_r    <= field_mem_r[cur_idx];
      s2_fend_r     <= s1_pix.fend;
    end
  end

  // Terms in summation order: left pair, upper pair, own field.
  assign tx = s2_left_hit_r ? sext_val(left_data) : '0;
  assign ty = s2_up_hit_r   ? sext_val(up_data)   : '0;
  assign tz = s2_own_r      ? sext_val(s2_field_r) : '0;

  // After a clip at the top only the falls below the limit remain, and
  // after a clip at the bottom only the rises above it.
  always_comb begin
    hi_y  = (ty < 0) ? ty : '0;
    lo_y  = (ty > 0) ? ty : '0;
    hi_yz = ((hi_y + tz) < 0) ? (hi_y + tz) : '0;
    lo_yz = ((lo_y + tz) > 0) ? (lo_y + tz) : '0;
    hi_z  = (tz < 0) ? tz : '0;
    lo_z  = (tz > 0) ? tz : '0;

    terms.p1   = tx;
    terms.p2   = tx + ty;
    terms.p3   = tx + ty + tz;
    terms.hi1  = mpe_pkg::ACC_MAX + sext_acc(hi_yz);
    terms.lo1  = mpe_pkg::ACC_MIN + sext_acc(lo_yz);
    terms.hi2  = mpe_pkg::ACC_MAX + sext_acc(hi_z);
    terms.lo2  = mpe_pkg::ACC_MIN + sext_acc(lo_z);
    terms.fend = s2_fend_r;
  end

  // Term stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_terms_r <= terms;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mpe_accum.sv =====
// ----------------------------------------------------------------------------
// Masked Potts energy: saturating accumulator and result register
// Adds one pixel's terms per cycle unless the pipeline holds, clipping at every
// step, and hands the frame energy to the output channel on the frame's last pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module mpe_accum (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      s3_valid,
  input  wire mpe_pkg::terms_t           s3_terms,
  output logic                           adv,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [mpe_pkg::ACC_W-1:0] out_energy,
  output logic                           out_saturated
);

  localparam int ACC_W  = mpe_pkg::ACC_W;
  localparam int PSUM_W = mpe_pkg::PSUM_W;
  localparam int EXT_W  = ACC_W + 1;

  function automatic logic signed [EXT_W-1:0] sext_ext(input logic signed [PSUM_W-1:0] v);
    return {{(EXT_W-PSUM_W){v[PSUM_W-1]}}, v};
  endfunction

  function automatic logic over_hi(input logic [EXT_W-1:0] s);
    return !s[EXT_W-1] && s[EXT_W-2];
  endfunction

  function automatic logic over_lo(input logic [EXT_W-1:0] s);
    return s[EXT_W-1] && !s[EXT_W-2];
  endfunction

  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic                    sat_r;
  logic                    sat_nxt;
  logic                    out_valid_r;
  logic signed [ACC_W-1:0] energy_r;
  logic                    out_sat_r;
  logic                    fire;
  logic signed [EXT_W-1:0] a_ext;
  logic signed [EXT_W-1:0] sum1;
  logic signed [EXT_W-1:0] sum2;
  logic signed [EXT_W-1:0] sum3;
  logic signed [ACC_W-1:0] result;
  logic                    clip;

  // The pipeline holds only while a frame result waits on a full output.
  assign adv  = !(s3_valid && s3_terms.fend && out_valid_r && !out_ready);
  assign fire = s3_valid && adv;

  // The three partial sums in parallel; the first one out of range decides.
  assign a_ext = {acc_r[ACC_W-1], acc_r};
  assign sum1  = a_ext + sext_ext(s3_terms.p1);
  assign sum2  = a_ext + sext_ext(s3_terms.p2);
  assign sum3  = a_ext + sext_ext(s3_terms.p3);

  always_comb begin
    clip = 1'b1;
    priority if (over_hi(sum1)) begin
      result = s3_terms.hi1;
    end else if (over_lo(sum1)) begin
      result = s3_terms.lo1;
    end else if (over_hi(sum2)) begin
      result = s3_terms.hi2;
    end else if (over_lo(sum2)) begin
      result = s3_terms.lo2;
    end else if (over_hi(sum3)) begin
      result = mpe_pkg::ACC_MAX;
    end else if (over_lo(sum3)) begin
      result = mpe_pkg::ACC_MIN;
    end else begin
      result = sum3[ACC_W-1:0];
      clip   = 1'b0;
    end
  end

  // Accumulator restarts after the frame's last pixel.
  always_comb begin
    acc_nxt = acc_r;
    sat_nxt = sat_r;
    if (fire) begin
      if (s3_terms.fend) begin
        acc_nxt = '0;
        sat_nxt = 1'b0;
      end else begin
        acc_nxt = result;
        sat_nxt = sat_r || clip;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      sat_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      sat_r <= sat_nxt;
    end
  end

  // Result register on the output channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && s3_terms.fend) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s3_terms.fend) begin
      energy_r  <= result;
      out_sat_r <= sat_r || clip;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_energy    = energy_r;
  assign out_saturated = out_sat_r;

endmodule

`default_nettype wire

// ===== rtl/mpe_checker.sv =====
// ----------------------------------------------------------------------------
// Masked Potts energy: port checker
// Watches the top level's ports for reset, output hold and result latency.
// ----------------------------------------------------------------------------
`default_nettype none

module mpe_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              cfg_valid,
  input wire logic                              cfg_ready,
  input wire logic [mpe_pkg::LEN_W-1:0]         cfg_row_length,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic [1:0]                        in_mode,
  input wire logic [mpe_pkg::CELL_W-1:0]        in_label,
  input wire logic                              in_mask_in,
  input wire logic                              in_frame_end,
  input wire logic [mpe_pkg::TIDX_W-1:0]        in_table_row,
  input wire logic [mpe_pkg::TIDX_W-1:0]        in_table_col,
  input wire logic signed [mpe_pkg::VAL_W-1:0]  in_table_value,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [mpe_pkg::ACC_W-1:0]  out_energy,
  input wire logic                              out_saturated
);

  logic fend_beat;

  assign fend_beat = in_valid && in_ready && in_frame_end &&
                     (in_mode == mpe_pkg::MODE_PIXEL);

  // Reset empties the output and starts the line store clearing pass.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("output or input channel active right after reset");

  // A waiting result beat keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_energy) && $stable(out_saturated))
    else $error("result beat changed before it was taken");

  // With the output drained, a frame's last pixel yields its result through the pipeline registers.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (fend_beat && out_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("frame result missing after the last pixel");

  // Configuration beats are never held off.
  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready || $past(!rst_n))
    else $error("configuration beat held off");

endmodule

bind masked_potts_energy_field mpe_checker u_mpe_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Masked Potts energy testbench
// Loads the pair and field tables, streams raster pixel beats with random
// idling on the input and result channels, and keeps a behavioral copy of
// the lattice state to predict every frame energy. Each result beat is
// compared field by field against the oldest pending frame.
// ---------------------------------------------------------------------------
module testbench;
  import mpe_pkg::*;

  // The fourth item kind, which the block ignores.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int PHASES        = 10;
  localparam int PHASE_BEATS   = 90;
  localparam int FULL_PIXELS   = 40;
  localparam int FULL_ROW      = 7;

  typedef struct packed {
    logic [1:0]              mode;
    logic [CELL_W-1:0]       label;
    logic                    mask;
    logic                    fend;
    logic [TIDX_W-1:0]       row;
    logic [TIDX_W-1:0]       col;
    logic signed [VAL_W-1:0] value;
  } lattice_beat_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] energy;
    logic                    saturated;
  } frame_energy_t;

  // Block ports; the driven inputs are at known values from time zero.
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [LEN_W-1:0]         cfg_row_length = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_mode = '0;
  logic [CELL_W-1:0]        in_label = '0;
  logic                     in_mask_in = 1'b0;
  logic                     in_frame_end = 1'b0;
  logic [TIDX_W-1:0]        in_table_row = '0;
  logic [TIDX_W-1:0]        in_table_col = '0;
  logic signed [VAL_W-1:0]  in_table_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [ACC_W-1:0]  out_energy;
  logic                     out_saturated;

  // Predicted lattice state.
  logic signed [VAL_W-1:0]  pair_w [MAX_LABELS][MAX_LABELS];
  logic signed [VAL_W-1:0]  field_w [MAX_LABELS];
  logic [CELL_W-1:0]        prev_row [MAX_COLS];
  logic [CELL_W-1:0]        left_lbl = '0;
  int                       col_pos = 0;
  bit                       top_row = 1'b1;
  logic signed [ACC_W-1:0]  acc = '0;
  bit                       acc_clipped = 1'b0;
  int                       row_len_q = MAX_COLS;
  frame_energy_t            expected_energy [$];

  int mismatches   = 0;
  int results_seen = 0;
  int beats_sent   = 0;
  int cycles       = 0;
  int out_hold     = 0;
  bit no_idle      = 1'b0;

  masked_potts_energy_field dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_row_length (cfg_row_length),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_label       (in_label),
    .in_mask_in     (in_mask_in),
    .in_frame_end   (in_frame_end),
    .in_table_row   (in_table_row),
    .in_table_col   (in_table_col),
    .in_table_value (in_table_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_energy     (out_energy),
    .out_saturated  (out_saturated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Idle cycles before a beat; zero often, and always zero in a burst.
  function automatic int draw_wait();
    if (no_idle) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 12));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatches++;
  endtask

  // Saturating accumulate, clipping at each single addition.
  function automatic void add_clipped(input logic signed [VAL_W-1:0] term);
    longint sum;
    sum = longint'(acc) + longint'(term);
    if (sum > longint'(ACC_MAX)) begin
      sum = longint'(ACC_MAX);
      acc_clipped = 1'b1;
    end
    if (sum < longint'(ACC_MIN)) begin
      sum = longint'(ACC_MIN);
      acc_clipped = 1'b1;
    end
    acc = sum[ACC_W-1:0];
  endfunction

  // A neighbour pair counts only when both cells take part and differ.
  function automatic void add_pair(input logic [CELL_W-1:0] a, input logic [CELL_W-1:0] b);
    if (a != 0 && b != 0 && a != b) add_clipped(pair_w[a - 1][b - 1]);
  endfunction

  // Apply one accepted beat to the predicted state; queue a frame energy
  // when the beat closes a frame.
  function automatic void update_lattice(input lattice_beat_t b);
    int eff;
    logic [CELL_W-1:0] cur;
    logic [CELL_W-1:0] up;
    frame_energy_t r;
    case (b.mode)
      MODE_PAIR: begin
        pair_w[b.row][b.col] = b.value;
        pair_w[b.col][b.row] = b.value;
      end
      MODE_FIELD: begin
        field_w[b.row] = b.value;
      end
      MODE_PIXEL: begin
        eff = (row_len_q == 0) ? 1 : ((row_len_q > MAX_COLS) ? MAX_COLS : row_len_q);
        cur = (b.mask && b.label >= 1 && b.label <= MAX_LABELS) ? b.label : '0;
        up = prev_row[col_pos];
        if (col_pos > 0) add_pair(cur, left_lbl);
        if (!top_row) add_pair(cur, up);
        if (cur != 0) add_clipped(field_w[cur - 1]);
        prev_row[col_pos] = cur;
        left_lbl = cur;
        col_pos++;
        if (col_pos >= eff) begin
          col_pos = 0;
          top_row = 1'b0;
        end
        if (b.fend) begin
          r.energy = acc;
          r.saturated = acc_clipped;
          expected_energy.push_back(r);
          acc = '0;
          acc_clipped = 1'b0;
          col_pos = 0;
          left_lbl = '0;
          top_row = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Result side: random back-pressure and the check of each energy beat.
  always @(posedge clk) begin : result_check
    frame_energy_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_energy.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no frame pending, energy %0d",
                                  results_seen, out_energy));
      end else begin
        want = expected_energy.pop_front();
        if (out_energy !== want.energy)
          report_mismatch($sformatf("result %0d energy: got %0d, expected %0d",
                                    results_seen, out_energy, want.energy));
        if (out_saturated !== want.saturated)
          report_mismatch($sformatf("result %0d saturated: got %0b, expected %0b",
                                    results_seen, out_saturated, want.saturated));
      end
      out_hold = draw_wait();
      out_ready <= (out_hold == 0);
    end else if (out_hold > 0) begin
      out_hold--;
      out_ready <= (out_hold == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic lattice_beat_t pixel_beat(input logic [CELL_W-1:0] label,
                                               input logic mask, input logic fend);
    lattice_beat_t b;
    b.mode  = MODE_PIXEL;
    b.label = label;
    b.mask  = mask;
    b.fend  = fend;
    b.row   = TIDX_W'($urandom_range(0, 7));
    b.col   = TIDX_W'($urandom_range(0, 7));
    b.value = VAL_W'($urandom);
    return b;
  endfunction

  // Table write; the pixel fields carry noise the block must ignore.
  function automatic lattice_beat_t table_beat(input logic [1:0] mode, input int row,
                                               input int col, input logic [VAL_W-1:0] value);
    lattice_beat_t b;
    b.mode  = mode;
    b.label = CELL_W'($urandom_range(0, 15));
    b.mask  = 1'($urandom_range(0, 1));
    b.fend  = 1'($urandom_range(0, 1));
    b.row   = TIDX_W'(row);
    b.col   = TIDX_W'(col);
    b.value = value;
    return b;
  endfunction

  function automatic lattice_beat_t noise_beat();
    case ($urandom_range(0, 2))
      0: return table_beat(MODE_PAIR, $urandom_range(0, 7), $urandom_range(0, 7),
                           VAL_W'($urandom));
      1: return table_beat(MODE_FIELD, $urandom_range(0, 7), $urandom_range(0, 7),
                           VAL_W'($urandom));
      default: return table_beat(MODE_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
                                 VAL_W'($urandom));
    endcase
  endfunction

  // Mostly valid labels, sometimes anything the field can hold.
  function automatic logic [CELL_W-1:0] pick_label();
    if ($urandom_range(0, 5) == 0) return CELL_W'($urandom_range(0, 15));
    return CELL_W'($urandom_range(1, MAX_LABELS));
  endfunction

  // Send one input beat after a random gap; valid stays high until accepted.
  task automatic send_beat(input lattice_beat_t b);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= b.mode;
    in_label       <= b.label;
    in_mask_in     <= b.mask;
    in_frame_end   <= b.fend;
    in_table_row   <= b.row;
    in_table_col   <= b.col;
    in_table_value <= b.value;
    do @(posedge clk); while (in_ready !== 1'b1);
    update_lattice(b);
    if (b.mode != MODE_UNUSED) beats_sent++;
  endtask

  // Stop sending, let every pending frame come back, then let the pipeline settle.
  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    while (expected_energy.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_row_length(input logic [LEN_W-1:0] len);
    cfg_valid      <= 1'b1;
    cfg_row_length <= len;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    row_len_q = len;
  endtask

  // One raster frame of random cells. A noisy frame may carry table writes
  // and ignored beats, masked-out cells, an early end, or no end at all.
  task automatic send_frame(input int pixels, input bit noisy);
    int i;
    bit left_open;
    bit early;
    left_open = noisy && ($urandom_range(0, 7) == 0);
    for (i = 0; i < pixels; i++) begin
      if (noisy && $urandom_range(0, 11) == 0) send_beat(noise_beat());
      early = noisy && ($urandom_range(0, 39) == 0);
      send_beat(pixel_beat(pick_label(), noisy ? ($urandom_range(0, 7) != 0) : 1'b1,
                           ((i == pixels - 1) && !left_open) || early));
      if (early) break;
    end
  endtask

  // Fill both tables completely, extremes included; a later write to the
  // mirrored position must win.
  task automatic test_table_load();
    int r;
    int c;
    for (r = 0; r < MAX_LABELS; r++)
      for (c = r; c < MAX_LABELS; c++)
        send_beat(table_beat(MODE_PAIR, r, c, VAL_W'($urandom)));
    send_beat(table_beat(MODE_PAIR, 0, 7, 16'sh8000));
    send_beat(table_beat(MODE_PAIR, 7, 7, 16'sh7fff));
    send_beat(table_beat(MODE_PAIR, 2, 5, 16'sh0123));
    send_beat(table_beat(MODE_PAIR, 5, 2, -16'sh0456));
    for (r = 0; r < MAX_LABELS; r++)
      send_beat(table_beat(MODE_FIELD, r, $urandom_range(0, 7), VAL_W'($urandom)));
    send_beat(table_beat(MODE_FIELD, 0, 5, 16'sh8000));
    send_beat(table_beat(MODE_FIELD, 7, 2, 16'sh7fff));
  endtask

  // Hand-built frames on three-column rows: equal neighbours, empty and
  // out-of-range labels, masked cells, ignored beats and table updates.
  task automatic test_directed_frames();
    send_beat(pixel_beat(4'd1, 1'b1, 1'b0));
    send_beat(pixel_beat(4'd2, 1'b1, 1'b0));
    send_beat(pixel_beat(4'd2, 1'b1, 1'b0));
    send_beat(pixel_beat(4'd15, 1'b1, 1'b0));
    send_beat(pixel_beat(4'd3, 1'b0, 1'b0));
    send_beat(pixel_beat(4'd1, 1'b1, 1'b0));
    send_beat(table_beat(MODE_UNUSED, 3, 4, 16'sh7fff));
    send_beat(table_beat(MODE_FIELD, 4, 6, -16'sh0200));
    send_beat(pixel_beat(4'd8, 1'b1, 1'b0));
    send_beat(pixel_beat(4'd8, 1'b1, 1'b0));
    send_beat(pixel_beat(4'd0, 1'b1, 1'b1));
    // A frame of a single cell has no neighbours at all.
    send_beat(pixel_beat(4'd4, 1'b1, 1'b1));
    // Labels above the state range behave as empty cells.
    send_beat(pixel_beat(4'd9, 1'b1, 1'b0));
    send_beat(pixel_beat(4'd10, 1'b1, 1'b1));
    // Rewrite the mirrored pair between labels 8 and 1, then use it.
    send_beat(table_beat(MODE_PAIR, 7, 0, -16'sh0001));
    send_beat(pixel_beat(4'd8, 1'b1, 1'b0));
    send_beat(pixel_beat(4'd1, 1'b1, 1'b1));
  endtask

  // Zero behaves as one column; lengths past the line store clamp to it.
  task automatic test_row_length_limits();
    wait_idle(SETTLE_CYCLES);
    set_row_length(11'd0);
    send_frame(5, 1'b0);
    wait_idle(SETTLE_CYCLES);
    set_row_length(11'd2047);
    send_frame(6, 1'b0);
    wait_idle(SETTLE_CYCLES);
    set_row_length(11'd1024);
    send_frame(4, 1'b0);
  endtask

  // Alternating labels 1 and 2 on an odd row length make every cell off the top row
  // and first column add its left pair, upper pair and field, all at full scale in each direction.
  task automatic test_full_scale();
    int s;
    int i;
    logic signed [VAL_W-1:0] v;
    wait_idle(SETTLE_CYCLES);
    no_idle = 1'b1;
    set_row_length(11'(FULL_ROW));
    for (s = 0; s < 2; s++) begin
      v = (s == 0) ? 16'sh8000 : 16'sh7fff;
      send_beat(table_beat(MODE_PAIR, 0, 1, v));
      send_beat(table_beat(MODE_FIELD, 0, 0, v));
      send_beat(table_beat(MODE_FIELD, 1, 0, v));
      for (i = 0; i < FULL_PIXELS; i++)
        send_beat(pixel_beat(CELL_W'(1 + i % 2), 1'b1, i == FULL_PIXELS - 1));
    end
    no_idle = 1'b0;
  endtask

  // Phases of random frames, each under its own row length; some phases
  // run without idling and some leave a frame open across the change.
  task automatic test_random_frames();
    int p;
    int eff;
    int n;
    int start;
    logic [LEN_W-1:0] len;
    for (p = 0; p < PHASES; p++) begin
      wait_idle(SETTLE_CYCLES);
      case (p)
        0: len = 11'd1;
        1: len = 11'd2;
        2: len = 11'd0;
        3: len = 11'd2047;
        4: len = 11'd1024;
        5: len = 11'd7;
        default: len = LEN_W'($urandom_range(1, 40));
      endcase
      set_row_length(len);
      eff = (len == 0) ? 1 : ((len > MAX_COLS) ? MAX_COLS : int'(len));
      no_idle = ($urandom_range(0, 3) == 0);
      start = beats_sent;
      while (beats_sent - start < PHASE_BEATS) begin
        if (eff <= 40)
          n = eff * $urandom_range(1, 3) + ($urandom_range(0, 1) ? $urandom_range(0, eff - 1) : 0);
        else
          n = $urandom_range(1, 20);
        send_frame(n, 1'b1);
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    foreach (prev_row[i]) prev_row[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // The first write lands while the line store is still being cleared.
    set_row_length(11'd3);
    test_table_load();
    test_directed_frames();
    test_row_length_limits();
    test_full_scale();
    test_random_frames();
    wait_idle(DRAIN_CYCLES);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
